// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/tlgr_pkg.sv =====
`default_nettype none

package tlgr_pkg;

  localparam int GLYPH_COUNT   = 96;
  localparam int GLYPH_COLUMNS = 12;
  localparam int LINE_COLUMNS  = 128;
  localparam int FIRST_CODE    = 32;

  localparam int GLYPH_BYTES = 1 + 2 * GLYPH_COLUMNS;
  localparam int FONT_BYTES  = GLYPH_BYTES * GLYPH_COUNT;
  localparam int FRAME_BYTES = 4 * LINE_COLUMNS;

  localparam int FONT_AW  = $clog2(FONT_BYTES);
  localparam int FRAME_AW = $clog2(FRAME_BYTES);
  localparam int CUR_W    = $clog2(LINE_COLUMNS + 1);
  localparam int GB_W     = $clog2(GLYPH_BYTES + 1);
  localparam int GC_W     = $clog2(GLYPH_COLUMNS + 1);
  localparam int COL_W    = $clog2(LINE_COLUMNS + GLYPH_COLUMNS);
  localparam int ADV_W    = $clog2(LINE_COLUMNS + 256);
  localparam int CODE_W   = 9;

  // Operation codes
  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_DRAW   = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_CURSOR = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLIP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic        line_sel;
    logic [7:0]  symbol;
    logic [11:0] mem_addr;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/text_line_glyph_renderer_unit.sv =====
// Glyph renderer for a two-line page framebuffer with a loadable proportional font.
// Command channel: an item is transferred at a rising edge with start high and busy low.
// Result channel: out_strobe is high for exactly one cycle per command, with out_item
// valid in that cycle; the receiver cannot stall, so a result is never held back.
// Every command yields exactly one result.
// Steps from accept to strobe:
//   load font byte, reset cursors, unused modes, symbol outside font: result registered
//   read framebuffer byte: registered framebuffer read, then the result register
//   draw character: the font store read port gives one byte per cycle for the 25
//     glyph bytes, then the cursor update with the result
//   clear line: one framebuffer byte written per cycle over the line's 256 bytes
// Commands do not overlap; busy is high for a whole read, draw or clear.
// After reset a clearing pass zeroes the whole framebuffer with busy high,
// and no result is produced for it. Cursors are zero after reset; the font store is
// not cleared and must be loaded before drawing.
`default_nettype none

module text_line_glyph_renderer_unit
  import tlgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_strobe,
  output out_item_t      out_item
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_DRAW
  } state_t;

  state_t                state_r;
  logic                  out_strobe_r;
  out_item_t             out_data_r;

  logic [CUR_W-1:0]      cur_first_r;
  logic [CUR_W-1:0]      cur_second_r;
  logic [CUR_W-1:0]      pos_r;
  logic                  line_r;
  logic [FRAME_AW-1:0]   base_r;

  logic [FRAME_AW-1:0]   clr_cnt_r;
  logic [FRAME_AW-1:0]   clr_last_r;
  logic                  clr_emit_r;

  logic [FONT_AW-1:0]    fptr_r;
  logic [GB_W-1:0]       k_r;
  logic                  dv_r;
  logic [GB_W-1:0]       dk_r;
  logic [7:0]            width_r;
  logic                  clipped_r;
  logic                  rd_ok_r;

  logic [7:0]            font_mem [FONT_BYTES];
  logic [7:0]            frame_mem [FRAME_BYTES];
  logic [7:0]            font_rd_r;
  logic [7:0]            frame_rd_r;

  logic                  in_fire;
  logic                  sym_ok;
  logic [CODE_W-1:0]     code_ext;
  logic [FONT_AW-1:0]    glyph_off;
  logic [GC_W-1:0]       col_i;
  logic [COL_W-1:0]      col;
  logic                  col_ok;
  logic                  lower;
  logic [ADV_W-1:0]      adv;
  logic                  adv_over;
  logic [CUR_W-1:0]      cur_new;
  logic                  fb_we;
  logic [FRAME_AW-1:0]   fb_wa;
  logic [7:0]            fb_wd;
  logic                  fb_re;
  logic                  font_we;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_data_r;
  assign in_fire    = start && (state_r == S_IDLE);

  assign code_ext  = CODE_W'(in_item.symbol);
  assign sym_ok    = (code_ext >= CODE_W'(FIRST_CODE)) &&
                     (code_ext < CODE_W'(FIRST_CODE + GLYPH_COUNT));
  assign glyph_off = FONT_AW'((code_ext - CODE_W'(FIRST_CODE)) * GLYPH_BYTES);

  // Byte k of a glyph: 0 is the width, odd is an upper column, even a lower one.
  assign col_i  = GC_W'((dk_r - GB_W'(1)) >> 1);
  assign lower  = !dk_r[0];
  assign col    = COL_W'(pos_r) + COL_W'(col_i);
  assign col_ok = (col < COL_W'(LINE_COLUMNS));

  assign adv      = ADV_W'(pos_r) + ADV_W'(width_r);
  assign adv_over = (adv > ADV_W'(LINE_COLUMNS));
  assign cur_new  = adv_over ? CUR_W'(LINE_COLUMNS) : CUR_W'(adv);

  always_comb begin
    fb_we = 1'b0;
    fb_wa = base_r + clr_cnt_r;
    fb_wd = '0;
    if (state_r == S_CLEAR) begin
      fb_we = 1'b1;
    end else if (state_r == S_DRAW && dv_r && dk_r != '0) begin
      fb_we = col_ok;
      fb_wa = base_r + (lower ? FRAME_AW'(LINE_COLUMNS) : '0) + FRAME_AW'(col);
      fb_wd = font_rd_r;
    end
  end

  assign fb_re   = in_fire && (in_item.mode == MODE_READ);
  assign font_we = in_fire && (in_item.mode == MODE_LOAD) &&
                   (in_item.mem_addr < FONT_AW'(FONT_BYTES));

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[in_item.mem_addr[FONT_AW-1:0]] <= in_item.font_byte;
    end
    font_rd_r <= font_mem[fptr_r];
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      frame_mem[fb_wa] <= fb_wd;
    end
    if (fb_re) begin
      frame_rd_r <= frame_mem[in_item.mem_addr[FRAME_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_strobe_r <= 1'b0;
      cur_first_r  <= '0;
      cur_second_r <= '0;
      base_r       <= '0;
      clr_cnt_r    <= '0;
      clr_last_r   <= FRAME_AW'(FRAME_BYTES - 1);
      clr_emit_r   <= 1'b0;
      k_r          <= '0;
      dv_r         <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            line_r     <= in_item.line_sel;
            base_r     <= in_item.line_sel ? FRAME_AW'(2 * LINE_COLUMNS) : '0;
            case (in_item.mode)
              MODE_DRAW: begin
                out_strobe_r <= !sym_ok;
                out_data_r   <= out_item_t'{read_data: 8'd0,
                                            status: sym_ok ? ST_OK : ST_RANGE};
                if (sym_ok) begin
                  state_r   <= S_DRAW;
                  fptr_r    <= glyph_off;
                  k_r       <= '0;
                  clipped_r <= 1'b0;
                  pos_r     <= in_item.line_sel ? cur_second_r : cur_first_r;
                end
              end
              MODE_CLEAR: begin
                state_r      <= S_CLEAR;
                out_strobe_r <= 1'b0;
                out_data_r   <= '0;
                clr_cnt_r    <= '0;
                clr_last_r   <= FRAME_AW'(2 * LINE_COLUMNS - 1);
                clr_emit_r   <= 1'b1;
              end
              MODE_CURSOR: begin
                cur_first_r  <= '0;
                cur_second_r <= '0;
                out_strobe_r <= 1'b1;
                out_data_r   <= '0;
              end
              MODE_READ: begin
                state_r      <= S_READ;
                out_strobe_r <= 1'b0;
                out_data_r   <= '0;
                rd_ok_r      <= (in_item.mem_addr < 12'(FRAME_BYTES));
              end
              default: begin
                out_strobe_r <= 1'b1;
                out_data_r   <= '0;
              end
            endcase
          end else begin
            out_strobe_r <= 1'b0;
          end
        end
        S_CLEAR: begin
          if (clr_cnt_r == clr_last_r) begin
            state_r      <= S_IDLE;
            clr_cnt_r    <= '0;
            out_strobe_r <= clr_emit_r;
            out_data_r   <= '0;
          end else begin
            clr_cnt_r    <= clr_cnt_r + FRAME_AW'(1);
            out_strobe_r <= 1'b0;
          end
        end
        S_READ: begin
          state_r      <= S_IDLE;
          out_strobe_r <= 1'b1;
          out_data_r   <= out_item_t'{read_data: rd_ok_r ? frame_rd_r : 8'd0,
                                      status: ST_OK};
        end
        S_DRAW: begin
          // Issue one font read per cycle; the data is handled in the next cycle.
          dv_r <= (k_r < GB_W'(GLYPH_BYTES));
          if (k_r < GB_W'(GLYPH_BYTES)) begin
            fptr_r <= fptr_r + FONT_AW'(1);
            k_r    <= k_r + GB_W'(1);
            dk_r   <= k_r;
          end
          if (dv_r) begin
            if (dk_r == '0) begin
              width_r <= font_rd_r;
            end else if (!col_ok) begin
              clipped_r <= 1'b1;
            end
          end
          if (dv_r && dk_r == GB_W'(GLYPH_BYTES - 1)) begin
            state_r      <= S_IDLE;
            out_strobe_r <= 1'b1;
            out_data_r   <= out_item_t'{read_data: 8'd0,
                                        status: (clipped_r || !col_ok || adv_over) ?
                                                ST_CLIP : ST_OK};
            if (line_r) begin
              cur_second_r <= cur_new;
            end else begin
              cur_first_r <= cur_new;
            end
          end else begin
            out_strobe_r <= 1'b0;
          end
        end
        default: begin
          state_r      <= S_IDLE;
          out_strobe_r <= 1'b0;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_answered, clk, rst_n, in_fire, busy || out_strobe_r)
  `ASSERT_SAME(a_no_result_mid_draw, clk, rst_n, state_r == S_DRAW, !out_strobe_r)
  `ASSERT_SAME(a_draw_write_in_line, clk, rst_n, fb_we && state_r == S_DRAW, col_ok)
  `ASSERT_SAME(a_cursor_bound, clk, rst_n, 1'b1,
               cur_first_r <= CUR_W'(LINE_COLUMNS) && cur_second_r <= CUR_W'(LINE_COLUMNS))

endmodule

`default_nettype wire

// ===== tb/tlgr_result_checker.sv =====
`timescale 1ns / 100ps

module tlgr_result_checker
  import tlgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_strobe,
  input  wire out_item_t out_item,
  output int             error_count,
  output int             pending_count,
  output int             checked_count
);

  // Shadow of the block's state
  logic [7:0]       frame_mem [FRAME_BYTES];
  logic [7:0]       font_mem  [FONT_BYTES];
  logic [CUR_W-1:0] line_cursor [2];

  out_item_t expected_results [$];
  int        mismatches;
  int        compared;

  initial begin
    foreach (font_mem[i]) font_mem[i] = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    line_cursor[0] = '0;
    line_cursor[1] = '0;
    mismatches = 0;
    compared = 0;
    error_count = 0;
    pending_count = 0;
    checked_count = 0;
  end

  // Blit one glyph at the row's cursor; returns the status code.
  function automatic logic [1:0] blit_glyph(input logic row, input logic [7:0] code);
    int   src;
    int   pos;
    int   col;
    int   adv;
    int   row_base;
    logic clipped;
    if (code < FIRST_CODE || code >= FIRST_CODE + GLYPH_COUNT) return ST_RANGE;
    src      = (code - FIRST_CODE) * GLYPH_BYTES;
    row_base = row ? 2 * LINE_COLUMNS : 0;
    pos      = line_cursor[row];
    clipped  = 1'b0;
    for (int i = 0; i < GLYPH_COLUMNS; i++) begin
      col = pos + i;
      if (col < LINE_COLUMNS) begin
        frame_mem[row_base + col]                = font_mem[src + 1 + 2 * i];
        frame_mem[row_base + LINE_COLUMNS + col] = font_mem[src + 2 + 2 * i];
      end else begin
        clipped = 1'b1;
      end
    end
    adv = pos + font_mem[src];
    if (adv > LINE_COLUMNS) begin
      adv     = LINE_COLUMNS;
      clipped = 1'b1;
    end
    line_cursor[row] = CUR_W'(adv);
    return clipped ? ST_CLIP : ST_OK;
  endfunction

  // Apply one command to the shadow state and return its result.
  function automatic out_item_t render_command(input in_item_t cmd);
    out_item_t res;
    int        row_base;
    res = '0;
    case (cmd.mode)
      MODE_LOAD: begin
        if (cmd.mem_addr < FONT_BYTES) font_mem[cmd.mem_addr] = cmd.font_byte;
      end
      MODE_DRAW: begin
        res.status = blit_glyph(cmd.line_sel, cmd.symbol);
      end
      MODE_CLEAR: begin
        row_base = cmd.line_sel ? 2 * LINE_COLUMNS : 0;
        for (int i = 0; i < 2 * LINE_COLUMNS; i++) frame_mem[row_base + i] = '0;
      end
      MODE_CURSOR: begin
        line_cursor[0] = '0;
        line_cursor[1] = '0;
      end
      MODE_READ: begin
        if (cmd.mem_addr < FRAME_BYTES) res.read_data = frame_mem[cmd.mem_addr];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (frame_mem[i]) frame_mem[i] = '0;
      line_cursor[0] = '0;
      line_cursor[1] = '0;
      expected_results.delete();
    end else begin
      // results first: a new command may be transferred on the edge its predecessor finishes
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: read_data=%0d status=%0d",
                 out_item.read_data, out_item.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compared++;
          if (out_item.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, out_item.read_data);
            mismatches++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(render_command(in_item));
    end
    error_count   <= mismatches;
    checked_count <= compared;
    pending_count <= expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tlgr_pkg::*;

  localparam int         ITEM_TARGET  = 550;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 300;
  localparam int         ADDR_MAX     = 4095;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  int error_count;
  int pending_count;
  int checked_count;

  int   sent_count;
  int   draw_count;
  int   glyph_loads;
  int   stall_cycles;
  logic quiet_stretch;
  logic glyph_loaded [GLYPH_COUNT];

  text_line_glyph_renderer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  tlgr_result_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_item      (out_item),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) quiet_stretch = !quiet_stretch;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Present one command and hold it until transferred
  task automatic issue(input in_item_t cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    if (cmd.mode == MODE_DRAW) draw_count++;
  endtask

  // Unused fields carry random noise
  task automatic issue_cmd(input logic [2:0] mode, input logic row, input logic [7:0] code,
                           input int addr, input int fbyte);
    in_item_t cmd;
    cmd = in_item_t'($urandom);
    cmd.mode = mode;
    cmd.line_sel = row;
    if (mode == MODE_DRAW) cmd.symbol = code;
    if (mode inside {MODE_LOAD, MODE_READ}) cmd.mem_addr = addr[11:0];
    if (mode == MODE_LOAD) cmd.font_byte = fbyte[7:0];
    issue(cmd);
  endtask

  task automatic load_glyph(input int g);
    int   r;
    int   advance;
    logic [7:0] byte_val;
    r = $urandom_range(0, 99);
    if (r < 10)      advance = 0;
    else if (r < 20) advance = 255;
    else if (r < 30) advance = $urandom_range(0, 255);
    else             advance = $urandom_range(1, GLYPH_COLUMNS + 2);
    for (int k = 0; k < GLYPH_BYTES; k++) begin
      byte_val = (k == 0) ? advance[7:0] : 8'($urandom);
      issue_cmd(MODE_LOAD, 1'($urandom), 8'($urandom), g * GLYPH_BYTES + k, byte_val);
    end
    glyph_loaded[g] = 1'b1;
    glyph_loads++;
  endtask

  function automatic int pick_loaded_glyph();
    int g;
    do g = $urandom_range(0, GLYPH_COUNT - 1); while (!glyph_loaded[g]);
    return g;
  endfunction

  initial begin
    int   r;
    int   g;
    int   addr;
    logic row;
    start         = 1'b0;
    in_item       = '0;
    rst_n         = 1'b0;
    sent_count    = 0;
    draw_count    = 0;
    glyph_loads   = 0;
    quiet_stretch = 1'b0;
    foreach (glyph_loaded[i]) glyph_loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range edges, out-of-font codes, every mode
    issue_cmd(MODE_READ, 1'b0, 8'd0, 0, 0);
    issue_cmd(MODE_READ, 1'b1, 8'd0, FRAME_BYTES - 1, 0);
    issue_cmd(MODE_READ, 1'b0, 8'd0, FRAME_BYTES, 0);
    issue_cmd(MODE_READ, 1'b1, 8'd0, ADDR_MAX, 0);
    issue_cmd(MODE_LOAD, 1'b0, 8'd0, FONT_BYTES, 255);
    issue_cmd(MODE_LOAD, 1'b1, 8'd0, ADDR_MAX, 0);
    issue_cmd(MODE_DRAW, 1'b0, 8'd0, 0, 0);
    issue_cmd(MODE_DRAW, 1'b1, 8'(FIRST_CODE - 1), 0, 0);
    issue_cmd(MODE_DRAW, 1'b0, 8'(FIRST_CODE + GLYPH_COUNT), 0, 0);
    issue_cmd(MODE_DRAW, 1'b1, 8'd255, 0, 0);
    issue_cmd(MODE_CLEAR, 1'b0, 8'd0, 0, 0);
    issue_cmd(MODE_CLEAR, 1'b1, 8'd0, 0, 0);
    issue_cmd(MODE_CURSOR, 1'b0, 8'd0, 0, 0);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      issue_cmd(3'(m), 1'($urandom), 8'($urandom), $urandom_range(0, ADDR_MAX), 0);

    // Random: glyph loads then mostly draws and read-backs
    while (sent_count < ITEM_TARGET) begin
      row = 1'($urandom);
      if (glyph_loads < 2) begin
        load_glyph((glyph_loads == 0) ? 0 : GLYPH_COUNT - 1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          load_glyph($urandom_range(0, GLYPH_COUNT - 1));
        end else if (r < 48) begin
          g = pick_loaded_glyph();
          issue_cmd(MODE_DRAW, row, 8'(FIRST_CODE + g), 0, 0);
        end else if (r < 53) begin
          issue_cmd(MODE_DRAW, row,
                    $urandom_range(0, 1) ? 8'($urandom_range(0, FIRST_CODE - 1))
                                         : 8'($urandom_range(FIRST_CODE + GLYPH_COUNT, 255)),
                    0, 0);
        end else if (r < 83) begin
          // bias towards low columns, where the cursors usually sit
          if (r < 65)
            addr = row * 2 * LINE_COLUMNS + $urandom_range(0, 1) * LINE_COLUMNS
                   + $urandom_range(0, 47);
          else if (r < 80)
            addr = $urandom_range(0, FRAME_BYTES - 1);
          else
            addr = $urandom_range(FRAME_BYTES, ADDR_MAX);
          issue_cmd(MODE_READ, row, 8'($urandom), addr, 0);
        end else if (r < 87) begin
          issue_cmd(MODE_CURSOR, row, 8'($urandom), 0, 0);
        end else if (r < 89) begin
          issue_cmd(MODE_CLEAR, row, 8'($urandom), 0, 0);
        end else if (r < 94) begin
          g = pick_loaded_glyph();
          issue_cmd(MODE_LOAD, row, 8'($urandom),
                    g * GLYPH_BYTES + $urandom_range(0, GLYPH_BYTES - 1), $urandom_range(0, 255));
        end else if (r < 97) begin
          issue_cmd(MODE_LOAD, row, 8'($urandom), $urandom_range(FONT_BYTES, ADDR_MAX),
                    $urandom_range(0, 255));
        end else begin
          issue_cmd(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), row, 8'($urandom),
                    $urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands: %0d draws, %0d glyph loads; %0d results compared.",
             sent_count, draw_count, glyph_loads, checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
